// ===== hdl/msl_pkg.sv =====
// ---------------------------------------------------------------------------
// msl_pkg
// Shared types, codes and constants of the servo slew limiter.
// ---------------------------------------------------------------------------
package msl_pkg;

  localparam int ELAPSED_W = 16;
  localparam int CH_W      = 4;
  localparam int VAL_W     = 12;
  localparam int CFG_W     = 12;
  localparam int CFG_IDX_W = 2;

  // input action codes
  localparam logic [1:0] ACT_TICK   = 2'd0;
  localparam logic [1:0] ACT_ADD    = 2'd1;
  localparam logic [1:0] ACT_SET    = 2'd2;
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  // result status codes
  localparam logic [1:0] ST_PULSE    = 2'd0;
  localparam logic [1:0] ST_OK       = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_UPDATE_DELAY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PULSE_ZERO   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PULSE_FULL   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ESC_OUT      = 2'd3;

  // configuration reset values
  localparam logic [9:0]      RST_UPDATE_DELAY = 10'd20;
  localparam logic [11:0]     RST_PULSE_ZERO   = 12'd102;
  localparam logic [11:0]     RST_PULSE_FULL   = 12'd512;
  localparam logic [CH_W-1:0] RST_ESC_OUT      = 4'd0;

  // arithmetic constants
  localparam logic [VAL_W-1:0] START_ANGLE  = 12'd135;
  localparam logic [10:0]      MS_PER_SEC   = 11'd1000;
  localparam logic [22:0]      RECIP_1000   = 23'd4294968;   // ceil(2^32/1000)
  localparam int               SH_1000      = 32;
  localparam logic [24:0]      RECIP_270    = 25'd31814573;  // ceil(2^33/270)
  localparam int               SH_270       = 33;
  localparam logic [8:0]       ANGLE_BIAS   = 9'd269;        // 270 - 1, for floor
  localparam logic [13:0]      RECIP_5      = 14'd13108;     // ceil(2^16/5)
  localparam int               SH_5         = 16;
  localparam logic [12:0]      ESC_BASE_US  = 13'd1500;
  localparam logic [12:0]      ESC_OFFSET   = 13'd210;
  localparam logic [11:0]      TICK_MAX     = 12'd4095;

  typedef enum logic [1:0] {
    CMD_TICK,
    CMD_ADD,
    CMD_SET
  } cmd_kind_t;

  typedef struct packed {
    logic [1:0]           action;
    logic [ELAPSED_W-1:0] elapsed_ms;
    logic [CH_W-1:0]      channel;
    logic [VAL_W-1:0]     target;
    logic [VAL_W-1:0]     speed_limit;
    logic                 esc_flag;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [CH_W-1:0]  pwm_channel;
    logic [VAL_W-1:0] off_tick;
    logic             last;
  } out_item_t;

  typedef struct packed {
    cmd_kind_t            kind;
    logic [ELAPSED_W-1:0] elapsed_ms;
    logic [CH_W-1:0]      channel;
    logic [VAL_W-1:0]     target;
    logic [VAL_W-1:0]     speed_limit;
    logic                 esc_flag;
  } cmd_t;

endpackage

// ===== hdl/msl_front.sv =====
// ---------------------------------------------------------------------------
// msl_front
// Takes input items, decodes the action and queues a command for the back end.
// ---------------------------------------------------------------------------
module msl_front import msl_pkg::*; (
  input  logic     in_valid,
  output logic     in_stall,
  input  in_item_t in_data,
  output logic     q_wr_valid,
  input  logic     q_wr_ready,
  output cmd_t     q_wr_data
);

  logic      known;
  cmd_kind_t kind;

  // decode action, unused code is taken and dropped
  always_comb begin
    known = 1'b1;
    kind  = CMD_TICK;
    case (in_data.action)
      ACT_TICK: kind = CMD_TICK;
      ACT_ADD:  kind = CMD_ADD;
      ACT_SET:  kind = CMD_SET;
      default:  known = 1'b0;
    endcase
  end

  // command packing
  always_comb begin
    q_wr_data.kind        = kind;
    q_wr_data.elapsed_ms  = in_data.elapsed_ms;
    q_wr_data.channel     = in_data.channel;
    q_wr_data.target      = in_data.target;
    q_wr_data.speed_limit = in_data.speed_limit;
    q_wr_data.esc_flag    = in_data.esc_flag;
  end

  assign in_stall   = !q_wr_ready;
  assign q_wr_valid = in_valid && known;

endmodule

// ===== hdl/msl_queue.sv =====
// ---------------------------------------------------------------------------
// msl_queue
// Two-entry command queue between the front and back ends.
// ---------------------------------------------------------------------------
module msl_queue import msl_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic wr_valid,
  output logic wr_ready,
  input  cmd_t wr_data,
  output logic rd_valid,
  input  logic rd_pop,
  output cmd_t rd_data
);

  cmd_t       slots [2];
  logic       wp;
  logic       rp;
  logic [1:0] fill;
  logic       push;
  logic       pop;

  assign wr_ready = (fill != 2'd2);
  assign rd_valid = (fill != 2'd0);
  assign rd_data  = slots[rp];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_pop && rd_valid;

  // slot storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wp] <= wr_data;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wp   <= 1'b0;
      rp   <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) begin
        wp <= !wp;
      end
      if (pop) begin
        rp <= !rp;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

// ===== hdl/msl_back.sv =====
// ---------------------------------------------------------------------------
// msl_back
// Command sequencer: channel table, step division, pulse mapping, results.
// ---------------------------------------------------------------------------
module msl_back import msl_pkg::*; #(
  parameter int MAX_CHANNELS = 16,
  parameter int FRAC_BITS    = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cmd_valid,
  output logic                 cmd_pop,
  input  cmd_t                 cmd,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_data
);

  localparam int IW  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int CW  = $clog2(MAX_CHANNELS + 1);
  localparam int PW  = VAL_W + FRAC_BITS;
  localparam int DW  = ELAPSED_W + FRAC_BITS;
  localparam int AW  = DW - 9;
  localparam int SAW = VAL_W + AW;
  localparam int SW  = SAW + 1;
  localparam int RK  = DW + 10;
  localparam int QW  = 2 * DW + 1;
  localparam logic [63:0]    RECIP_WIDE = ((64'd1 << RK) + 64'd999) / 64'd1000;
  localparam logic [DW:0]    RECIP_Q    = RECIP_WIDE[DW:0];
  localparam logic [CW-1:0]  FULL_CNT  = CW'(MAX_CHANNELS);
  localparam logic [PW-1:0]  START_POS = PW'(START_ANGLE) << FRAC_BITS;

  typedef enum logic [3:0] {
    S_IDLE, S_DIV, S_DREM, S_RD, S_EVAL, S_STEP, S_UPD, S_TICK, S_FIN,
    S_EMIT, S_FLUSH, S_SRCH, S_SCMP, S_REPLY
  } state_t;

  state_t state;

  // configuration
  logic [9:0]      update_delay_ms;
  logic [11:0]     pulse_at_zero;
  logic [11:0]     pulse_at_full;
  logic [CH_W-1:0] esc_out_chan;

  // control and working registers
  logic [CW-1:0]        count;
  logic [ELAPSED_W-1:0] acc;
  cmd_t                 cur;
  logic [DW-1:0]        div_num;
  logic [9:0]           div_rem;
  logic [DW-1:0]        div_quo;
  logic [IW-1:0]        idx;
  logic [CH_W-1:0]      e_chan;
  logic                 e_esc;
  logic [VAL_W-1:0]     e_speed;
  logic [VAL_W-1:0]     e_target;
  logic [PW-1:0]        e_pos;
  logic [SAW-1:0]       sa;
  logic [21:0]          sr;
  logic [12:0]          qr;
  logic [VAL_W-1:0]     ip;
  logic signed [25:0]   x_prod;
  logic [VAL_W-1:0]     esc_tick;
  out_item_t            res;
  out_item_t            hold;
  logic                 hold_valid;

  // channel table
  logic [CH_W-1:0]  mem_chan   [MAX_CHANNELS];
  logic             mem_esc    [MAX_CHANNELS];
  logic [VAL_W-1:0] mem_speed  [MAX_CHANNELS];
  logic [VAL_W-1:0] mem_target [MAX_CHANNELS];
  logic [PW-1:0]    mem_pos    [MAX_CHANNELS];
  logic [CH_W-1:0]  rd_chan;
  logic             rd_esc;
  logic [VAL_W-1:0] rd_speed;
  logic [VAL_W-1:0] rd_target;
  logic [PW-1:0]    rd_pos;

  logic             mem_we;
  logic [IW-1:0]    mem_wa;
  logic [CH_W-1:0]  wd_chan;
  logic             wd_esc;
  logic [VAL_W-1:0] wd_speed;
  logic [VAL_W-1:0] wd_target;
  logic [PW-1:0]    wd_pos;

  // combinational helpers
  logic                 out_free;
  logic                 out_load;
  logic [ELAPSED_W:0]   acc_sum;
  logic [ELAPSED_W-1:0] acc_sat;
  logic [QW-1:0]        dq_prod;
  logic                 idx_last;
  logic [PW-1:0]        rd_tfx;
  logic [PW-1:0]        e_tfx;
  logic [44:0]          q_prod;
  logic [SW-1:0]        step;
  logic [PW-1:0]        diff;
  logic [PW-1:0]        new_pos;
  logic signed [12:0]   ed;
  logic                 ed_neg;
  logic [12:0]          ed_abs;
  logic [12:0]          ed_mag2;
  logic [26:0]          p5;
  logic [10:0]          q5;
  logic signed [12:0]   ev;
  logic                 xneg;
  logic [25:0]          x_abs;
  logic [24:0]          x_mag;
  logic [49:0]          p270;
  logic [16:0]          q270;
  logic signed [18:0]   sv;
  logic [VAL_W-1:0]     servo_tick;

  assign out_free = !out_valid || !out_stall;
  assign cmd_pop  = (state == S_IDLE) && cmd_valid;

  // output register loads
  always_comb begin
    case (state)
      S_EMIT, S_FLUSH: out_load = hold_valid && out_free;
      S_REPLY:         out_load = out_free;
      default:         out_load = 1'b0;
    endcase
  end

  // saturating millisecond accumulation
  assign acc_sum = {1'b0, acc} + {1'b0, cmd.elapsed_ms};
  assign acc_sat = acc_sum[ELAPSED_W] ? '1 : acc_sum[ELAPSED_W-1:0];

  // scaled accumulator over 1000 through a reciprocal multiply
  assign dq_prod = QW'(div_num) * QW'(RECIP_Q);

  assign idx_last = ((CW'(idx) + CW'(1)) == count);
  assign rd_tfx   = PW'(rd_target) << FRAC_BITS;
  assign e_tfx    = PW'(e_target) << FRAC_BITS;

  // step = speed*quot + floor(speed*rem/1000)
  assign q_prod = 45'(sr) * 45'(RECIP_1000);
  assign step   = SW'(sa) + SW'(qr);
  assign diff   = (e_tfx > e_pos) ? (e_tfx - e_pos) : (e_pos - e_tfx);

  always_comb begin
    if (SW'(diff) <= step) begin
      new_pos = e_tfx;
    end else if (e_tfx > e_pos) begin
      new_pos = e_pos + step[PW-1:0];
    end else begin
      new_pos = e_pos - step[PW-1:0];
    end
  end

  // speed controller pulse: trunc(2*(p-1500)/5) + 210
  assign ed      = $signed({1'b0, ip}) - $signed(ESC_BASE_US);
  assign ed_neg  = ed[12];
  assign ed_abs  = ed_neg ? 13'(-ed) : 13'(ed);
  assign ed_mag2 = 13'(ed_abs << 1);
  assign p5      = 27'(ed_mag2) * 27'(RECIP_5);
  assign q5      = p5[26:SH_5];
  assign ev      = ed_neg ? ($signed(ESC_OFFSET) - $signed({2'b0, q5}))
                          : ($signed(ESC_OFFSET) + $signed({2'b0, q5}));

  // servo pulse: zero + floor(span*angle/270), negative side rounds down
  assign xneg  = x_prod[25];
  assign x_abs = xneg ? 26'(-x_prod) : 26'(x_prod);
  assign x_mag = 25'(x_abs + (xneg ? 26'(ANGLE_BIAS) : 26'd0));
  assign p270  = 50'(x_mag) * 50'(RECIP_270);
  assign q270  = p270[49:SH_270];
  assign sv    = xneg ? ($signed({7'b0, pulse_at_zero}) - $signed({2'b0, q270}))
                      : ($signed({7'b0, pulse_at_zero}) + $signed({2'b0, q270}));

  always_comb begin
    if (sv < 0) begin
      servo_tick = '0;
    end else if (sv > $signed({7'b0, TICK_MAX})) begin
      servo_tick = TICK_MAX;
    end else begin
      servo_tick = sv[VAL_W-1:0];
    end
  end

  // table write port
  always_comb begin
    mem_we    = 1'b0;
    mem_wa    = idx;
    wd_chan   = e_chan;
    wd_esc    = e_esc;
    wd_speed  = e_speed;
    wd_target = e_target;
    wd_pos    = new_pos;
    case (state)
      S_IDLE: begin
        if (cmd_valid && cmd.kind == CMD_ADD && count != FULL_CNT) begin
          mem_we    = 1'b1;
          mem_wa    = count[IW-1:0];
          wd_chan   = cmd.channel;
          wd_esc    = cmd.esc_flag;
          wd_speed  = cmd.speed_limit;
          wd_target = cmd.target;
          wd_pos    = START_POS;
        end
      end
      S_UPD: begin
        mem_we = 1'b1;
      end
      S_SCMP: begin
        if (rd_chan == cur.channel) begin
          mem_we    = 1'b1;
          wd_chan   = rd_chan;
          wd_esc    = rd_esc;
          wd_speed  = rd_speed;
          wd_target = cur.target;
          wd_pos    = rd_pos;
        end
      end
      default: mem_we = 1'b0;
    endcase
  end

  // table memory with registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_chan[mem_wa]   <= wd_chan;
      mem_esc[mem_wa]    <= wd_esc;
      mem_speed[mem_wa]  <= wd_speed;
      mem_target[mem_wa] <= wd_target;
      mem_pos[mem_wa]    <= wd_pos;
    end
    rd_chan   <= mem_chan[idx];
    rd_esc    <= mem_esc[idx];
    rd_speed  <= mem_speed[idx];
    rd_target <= mem_target[idx];
    rd_pos    <= mem_pos[idx];
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      update_delay_ms <= RST_UPDATE_DELAY;
      pulse_at_zero   <= RST_PULSE_ZERO;
      pulse_at_full   <= RST_PULSE_FULL;
      esc_out_chan    <= RST_ESC_OUT;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_UPDATE_DELAY: update_delay_ms <= cfg_data[9:0];
        CFG_PULSE_ZERO:   pulse_at_zero   <= cfg_data;
        CFG_PULSE_FULL:   pulse_at_full   <= cfg_data;
        CFG_ESC_OUT:      esc_out_chan    <= cfg_data[CH_W-1:0];
        default:          update_delay_ms <= update_delay_ms;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      acc        <= '0;
      hold_valid <= 1'b0;
      out_valid  <= 1'b0;
      idx        <= '0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            cur <= cmd;
            res.pwm_channel <= cmd.channel;
            res.off_tick    <= '0;
            res.last        <= 1'b1;
            idx             <= '0;
            case (cmd.kind)
              CMD_TICK: begin
                if (acc_sat < ELAPSED_W'(update_delay_ms)) begin
                  acc <= acc_sat;
                end else begin
                  acc     <= '0;
                  div_num <= DW'(acc_sat) << FRAC_BITS;
                  state   <= S_DIV;
                end
              end
              CMD_ADD: begin
                if (count == FULL_CNT) begin
                  res.status <= ST_FULL;
                end else begin
                  res.status <= ST_OK;
                  count      <= count + CW'(1);
                end
                state <= S_REPLY;
              end
              CMD_SET: begin
                if (count == '0) begin
                  res.status <= ST_NOTFOUND;
                  state      <= S_REPLY;
                end else begin
                  state <= S_SRCH;
                end
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_DIV: begin
          div_quo <= DW'(dq_prod[QW-1:RK]);
          state   <= S_DREM;
        end
        S_DREM: begin
          div_rem <= 10'(div_num - div_quo * DW'(MS_PER_SEC));
          state   <= (count == '0) ? S_FLUSH : S_RD;
        end
        S_RD: begin
          state <= S_EVAL;
        end
        S_EVAL: begin
          e_chan   <= rd_chan;
          e_esc    <= rd_esc;
          e_speed  <= rd_speed;
          e_target <= rd_target;
          e_pos    <= rd_pos;
          sa       <= SAW'(rd_speed) * SAW'(div_quo[AW-1:0]);
          sr       <= 22'(rd_speed) * 22'(div_rem);
          if (rd_pos != rd_tfx) begin
            state <= S_STEP;
          end else if (idx_last) begin
            state <= S_FLUSH;
          end else begin
            idx   <= idx + IW'(1);
            state <= S_RD;
          end
        end
        S_STEP: begin
          qr    <= q_prod[44:SH_1000];
          state <= S_UPD;
        end
        S_UPD: begin
          ip    <= new_pos[PW-1:FRAC_BITS];
          state <= S_TICK;
        end
        S_TICK: begin
          x_prod   <= ($signed({1'b0, pulse_at_full}) - $signed({1'b0, pulse_at_zero}))
                      * $signed({1'b0, ip});
          esc_tick <= ev[12] ? '0 : ev[VAL_W-1:0];
          state    <= S_FIN;
        end
        S_FIN: begin
          res.status      <= ST_PULSE;
          res.pwm_channel <= e_esc ? esc_out_chan : e_chan;
          res.off_tick    <= e_esc ? esc_tick : servo_tick;
          res.last        <= 1'b0;
          state           <= S_EMIT;
        end
        S_EMIT: begin
          if (!hold_valid || out_free) begin
            if (hold_valid) begin
              out_data <= hold;
            end
            hold       <= res;
            hold_valid <= 1'b1;
            if (idx_last) begin
              state <= S_FLUSH;
            end else begin
              idx   <= idx + IW'(1);
              state <= S_RD;
            end
          end
        end
        S_FLUSH: begin
          if (!hold_valid) begin
            state <= S_IDLE;
          end else if (out_free) begin
            out_data   <= '{status: hold.status, pwm_channel: hold.pwm_channel,
                            off_tick: hold.off_tick, last: 1'b1};
            hold_valid <= 1'b0;
            state      <= S_IDLE;
          end
        end
        S_SRCH: begin
          state <= S_SCMP;
        end
        S_SCMP: begin
          if (rd_chan == cur.channel) begin
            res.status <= ST_OK;
            state      <= S_REPLY;
          end else if (idx_last) begin
            res.status <= ST_NOTFOUND;
            state      <= S_REPLY;
          end else begin
            idx   <= idx + IW'(1);
            state <= S_SRCH;
          end
        end
        S_REPLY: begin
          if (out_free) begin
            out_data <= res;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // table never grows past its size
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_CNT)
    else $error("entry count beyond table size");

  // a held pulse never survives into idle
  a_hold_idle: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !hold_valid)
    else $error("pulse result left behind");

  // accumulator is cleared while a step is being divided out
  a_acc_clear: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> acc == '0)
    else $error("accumulator not cleared on step");

  // replies to add and set target are single results
  a_reply_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status != ST_PULSE |-> out_data.last)
    else $error("reply without last mark");

endmodule

// ===== hdl/multi_channel_servo_slew_limiter_core.sv =====
// ---------------------------------------------------------------------------
// multi_channel_servo_slew_limiter_core
// Slew limiter for up to MAX_CHANNELS servo or speed controller outputs. A
// two-entry command queue lets the input side keep taking items while the
// sequencer works. An add passes through S_IDLE and S_REPLY; a set target
// through S_IDLE, S_SRCH and S_SCMP per entry searched, then S_REPLY. A tick
// below the update delay accumulates in S_IDLE; a tick that steps divides
// the scaled accumulator by 1000 with a reciprocal multiply in S_DIV and
// S_DREM, then walks the table one entry at a time through its single read
// port: S_RD and S_EVAL for an entry already at target, S_RD to S_EMIT for
// an entry that moves and emits a pulse update, and S_FLUSH for the final
// result. Each output transfer waits for the output register to be free.
// ---------------------------------------------------------------------------
module multi_channel_servo_slew_limiter_core import msl_pkg::*; #(
  parameter int MAX_CHANNELS = 16,
  parameter int FRAC_BITS    = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  logic q_wr_valid;
  logic q_wr_ready;
  cmd_t q_wr_data;
  logic q_rd_valid;
  logic q_rd_pop;
  cmd_t q_rd_data;

  // input decode
  msl_front u_front (
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .q_wr_valid (q_wr_valid),
    .q_wr_ready (q_wr_ready),
    .q_wr_data  (q_wr_data)
  );

  // command queue
  msl_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (q_wr_valid),
    .wr_ready (q_wr_ready),
    .wr_data  (q_wr_data),
    .rd_valid (q_rd_valid),
    .rd_pop   (q_rd_pop),
    .rd_data  (q_rd_data)
  );

  // sequencer and table
  msl_back #(
    .MAX_CHANNELS (MAX_CHANNELS),
    .FRAC_BITS    (FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (q_rd_valid),
    .cmd_pop   (q_rd_pop),
    .cmd       (q_rd_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
